// File: sv/prq_pkg.sv
// Package for the position report queue: port widths, codes, register resets
// and the packed layouts of the item words and of one stored entry.
// No dependencies.
package prq_pkg;

   localparam int QUEUE_DEPTH_DEF = 512;

   localparam int REQ_DATA_W = 192;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 160;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam int INTERVAL_W = 9;
   localparam int LIMIT_W = 10;
   localparam int COUNT_OUT_W = 10;
   localparam int INDEX_W = 9;

   localparam logic [INTERVAL_W-1:0] INTERVAL_MIN = 9'd5;
   localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = 9'd300;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 9'd60;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd30;
   localparam logic [LIMIT_W-1:0] CIRCLE_LIMIT_MIN = 10'd60;

   localparam logic [REQ_USER_W-1:0] REQ_FIX = 2'd0;
   localparam logic [REQ_USER_W-1:0] REQ_ACK = 2'd1;
   localparam logic [REQ_USER_W-1:0] REQ_READ = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALWAYS_ON = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT = 2'd2;

   typedef struct packed {
      logic [11:0]        heading;
      logic [16:0]        speed;
      logic signed [18:0] altitude;
      logic signed [31:0] longitude;
      logic signed [30:0] latitude;
      logic [31:0]        stamp;
   } entry_type;

   typedef struct packed {
      logic [4:0]         pad;
      logic [8:0]         read_index;
      logic [31:0]        ack_time;
      logic [11:0]        heading;
      logic [16:0]        speed;
      logic signed [18:0] altitude;
      logic signed [31:0] longitude;
      logic signed [30:0] latitude;
      logic [31:0]        fix_time;
      logic               circling;
      logic               flying;
      logic               nav_invalid;
   } req_data_type;

   typedef struct packed {
      logic [3:0]         pad;
      logic [11:0]        read_heading;
      logic [16:0]        read_speed;
      logic signed [18:0] read_altitude;
      logic signed [31:0] read_longitude;
      logic signed [30:0] read_latitude;
      logic [31:0]        read_time;
      logic               read_valid;
      logic [9:0]         entry_count;
      logic               notify;
      logic               accepted;
   } rsp_data_type;

   typedef struct packed {
      logic        eval;
      logic [31:0] fix_time;
   } sched_cmd_type;

endpackage

// File: sv/prq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/prq_sched.sv
// Report schedule: holds the next due time and tells whether a fix is due.
// Depends on prq_pkg.
module prq_sched (
   input  logic                                clock,
   input  logic                                reset,
   input  prq_pkg::sched_cmd_type              sched_cmd,
   input  logic [prq_pkg::INTERVAL_W-1:0]      interval_s,
   output logic                                due
);

   logic [31:0]                     next_due_ff, next_due_in;
   logic                            sched_set_ff, sched_set_in;
   logic [prq_pkg::INTERVAL_W-1:0]  interval_eff;
   logic [31:0]                     target;

   always_comb begin
      interval_eff = interval_s;
      if (interval_s < prq_pkg::INTERVAL_MIN) begin
         interval_eff = prq_pkg::INTERVAL_MIN;
      end else if (interval_s > prq_pkg::INTERVAL_MAX) begin
         interval_eff = prq_pkg::INTERVAL_MAX;
      end
      target = sched_cmd.fix_time + 32'(interval_eff);
      due = sched_cmd.fix_time >= (sched_set_ff ? next_due_ff : target);
      next_due_in = next_due_ff;
      sched_set_in = sched_set_ff;
      if (sched_cmd.eval && (due || !sched_set_ff)) begin
         next_due_in = target;
         sched_set_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_due_ff <= '0;
         sched_set_ff <= 1'b0;
      end else begin
         next_due_ff <= next_due_in;
         sched_set_ff <= sched_set_in;
      end
   end

endmodule

// File: sv/position_report_queue.sv
// Top level of the position report queue: channel handshakes, configuration
// registers, queue pointers and the sequencer. Depends on prq_pkg, prq_ram, prq_sched.
//
//   Channel   Direction  Handshake            Content
//   req_      in         tvalid/tready        tuser: operation; tdata: fix, ack, read fields
//   rsp_      out        tvalid/tready        tdata: result of one operation
//   csr_      in         we (no wait)         register index and write data
//
// A fix and a read each step through their own states; an acknowledge reads nothing
// on an empty queue and otherwise pops entries one by one, since it
// walks the entry RAM through its single read port. An unused operation code goes
// straight to the result. Reset empties the queue and clears the schedule at once;
// stored entries are never cleared. A waiting result does not stop the next
// item being accepted; the result of that item then waits until the output frees.
module position_report_queue #(
   parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // nav_invalid, flying, circling, fix_time, latitude, longitude, altitude,
   // speed, heading, ack_time, read_index, zero padding
   input  logic [prq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type
   input  logic [prq_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // accepted, notify, entry_count, read_valid, read_time, read_latitude,
   // read_longitude, read_altitude, read_speed, read_heading, zero padding
   output logic [prq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [prq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [prq_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = (CW > prq_pkg::LIMIT_W) ? CW : prq_pkg::LIMIT_W;
   localparam int EW = $bits(prq_pkg::entry_type);
   localparam logic [PW:0] DEPTH_S = (PW + 1)'(QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
   localparam logic [AW-1:0] DEPTH_A = AW'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIX_EVAL,
      S_FIX_CHECK,
      S_ACK_RD,
      S_ACK_CMP,
      S_READ_RD,
      S_READ_DATA,
      S_DONE
   } state_type;

   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                             input logic [PW-1:0] off);
      logic [PW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[PW-1:0];
   endfunction

   state_type                        state_ff, state_in;
   prq_pkg::req_data_type            item_ff, item_in;
   logic [PW-1:0]                    head_ff, head_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [prq_pkg::INTERVAL_W-1:0]   interval_ff, interval_in;
   logic                             always_on_ff, always_on_in;
   logic [prq_pkg::LIMIT_W-1:0]      limit_ff, limit_in;
   logic                             try_ff, try_in;
   logic                             note_try_ff, note_try_in;
   logic                             acc_ff, acc_in;
   logic                             note_ff, note_in;
   logic                             rd_valid_ff, rd_valid_in;
   prq_pkg::entry_type               rd_entry_ff, rd_entry_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   prq_pkg::rsp_data_type            rsp_data_ff, rsp_data_in;

   logic                             ram_we;
   logic [PW-1:0]                    ram_waddr;
   prq_pkg::entry_type               ram_wdata;
   logic                             ram_re;
   logic [PW-1:0]                    ram_raddr;
   logic [EW-1:0]                    ram_rdata_raw;
   prq_pkg::entry_type               ram_rdata;
   prq_pkg::sched_cmd_type           sched_cmd;
   logic                             due;

   logic [AW-1:0]                    limit_eff;
   logic [AW-1:0]                    count_ext;
   logic [AW-1:0]                    newest_ext;
   logic [AW-1:0]                    index_ext;
   logic [PW-1:0]                    head_next;
   logic [PW-1:0]                    slot_tail;
   logic [PW-1:0]                    slot_newest;
   logic [PW-1:0]                    slot_read;
   logic                             qualified;
   logic                             fresh;

   prq_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = prq_pkg::entry_type'(ram_rdata_raw);

   prq_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .sched_cmd  (sched_cmd),
      .interval_s (interval_ff),
      .due        (due)
   );

   always_comb begin
      limit_eff = AW'(limit_ff);
      if (limit_eff == '0) begin
         limit_eff = AW'(1);
      end else if (limit_eff > DEPTH_A) begin
         limit_eff = DEPTH_A;
      end
      count_ext = AW'(count_ff);
      newest_ext = AW'(count_ff - CW'(1));
      index_ext = AW'(item_ff.read_index);
      head_next = (head_ff == LAST_SLOT) ? '0 : head_ff + PW'(1);
      slot_tail = slot_of(head_ff, count_ext[PW-1:0]);
      slot_newest = slot_of(head_ff, newest_ext[PW-1:0]);
      slot_read = slot_of(head_ff, index_ext[PW-1:0]);
      qualified = !item_ff.nav_invalid && (always_on_ff || item_ff.flying);
      fresh = (count_ff == '0) ||
              ({1'b0, ram_rdata.stamp} + 33'd1 <= {1'b0, item_ff.fix_time});
   end

   always_comb begin
      state_in = state_ff;
      item_in = item_ff;
      head_in = head_ff;
      count_in = count_ff;
      interval_in = interval_ff;
      always_on_in = always_on_ff;
      limit_in = limit_ff;
      try_in = try_ff;
      note_try_in = note_try_ff;
      acc_in = acc_ff;
      note_in = note_ff;
      rd_valid_in = rd_valid_ff;
      rd_entry_in = rd_entry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      ram_we = 1'b0;
      ram_waddr = slot_tail;
      ram_wdata.stamp = item_ff.fix_time;
      ram_wdata.latitude = item_ff.latitude;
      ram_wdata.longitude = item_ff.longitude;
      ram_wdata.altitude = item_ff.altitude;
      ram_wdata.speed = item_ff.speed;
      ram_wdata.heading = item_ff.heading;
      ram_re = 1'b0;
      ram_raddr = '0;
      sched_cmd.eval = 1'b0;
      sched_cmd.fix_time = item_ff.fix_time;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_index)
            prq_pkg::CSR_INTERVAL:  interval_in = csr_wdata[prq_pkg::INTERVAL_W-1:0];
            prq_pkg::CSR_ALWAYS_ON: always_on_in = csr_wdata[0];
            prq_pkg::CSR_LIMIT:     limit_in = csr_wdata[prq_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in = prq_pkg::req_data_type'(req_tdata);
               acc_in = 1'b0;
               note_in = 1'b0;
               rd_valid_in = 1'b0;
               rd_entry_in = '0;
               unique case (req_tuser)
                  prq_pkg::REQ_FIX:  state_in = S_FIX_EVAL;
                  prq_pkg::REQ_ACK:  state_in = S_ACK_RD;
                  prq_pkg::REQ_READ: state_in = S_READ_RD;
                  default:           state_in = S_DONE;
               endcase
            end
         end
         S_FIX_EVAL: begin
            sched_cmd.eval = qualified;
            try_in = qualified && (due || (item_ff.circling &&
                     limit_eff >= AW'(prq_pkg::CIRCLE_LIMIT_MIN)));
            note_try_in = qualified && due;
            ram_re = 1'b1;
            ram_raddr = slot_newest;
            state_in = S_FIX_CHECK;
         end
         S_FIX_CHECK: begin
            // A queue at its entry limit drops its oldest entry; the new one lands in the
            // slot past the tail either way.
            if (try_ff && fresh) begin
               ram_we = 1'b1;
               acc_in = 1'b1;
               note_in = note_try_ff;
               if (count_ext >= limit_eff) begin
                  head_in = head_next;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            state_in = S_DONE;
         end
         S_ACK_RD: begin
            if (count_ff == '0) begin
               state_in = S_DONE;
            end else begin
               ram_re = 1'b1;
               ram_raddr = head_ff;
               state_in = S_ACK_CMP;
            end
         end
         S_ACK_CMP: begin
            if (count_ff != '0 && ram_rdata.stamp <= item_ff.ack_time) begin
               head_in = head_next;
               count_in = count_ff - CW'(1);
               ram_re = 1'b1;
               ram_raddr = head_next;
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ_RD: begin
            if (index_ext < count_ext) begin
               ram_re = 1'b1;
               ram_raddr = slot_read;
               state_in = S_READ_DATA;
            end else begin
               state_in = S_DONE;
            end
         end
         S_READ_DATA: begin
            rd_valid_in = 1'b1;
            rd_entry_in = ram_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.pad = '0;
               rsp_data_in.accepted = acc_ff;
               rsp_data_in.notify = note_ff;
               rsp_data_in.entry_count = count_ext[prq_pkg::COUNT_OUT_W-1:0];
               rsp_data_in.read_valid = rd_valid_ff;
               rsp_data_in.read_time = rd_entry_ff.stamp;
               rsp_data_in.read_latitude = rd_entry_ff.latitude;
               rsp_data_in.read_longitude = rd_entry_ff.longitude;
               rsp_data_in.read_altitude = rd_entry_ff.altitude;
               rsp_data_in.read_speed = rd_entry_ff.speed;
               rsp_data_in.read_heading = rd_entry_ff.heading;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         interval_ff <= prq_pkg::INTERVAL_RESET;
         always_on_ff <= 1'b0;
         limit_ff <= prq_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         count_ff <= count_in;
         interval_ff <= interval_in;
         always_on_ff <= always_on_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      try_ff <= try_in;
      note_try_ff <= note_try_in;
      acc_ff <= acc_in;
      note_ff <= note_in;
      rd_valid_ff <= rd_valid_in;
      rd_entry_ff <= rd_entry_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count exceeds the queue depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_SLOT)
      else $error("head pointer outside the queue");

   a_notify_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.notify |-> rsp_data_ff.accepted)
      else $error("notify raised for a fix that was not stored");

   a_read_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.read_valid |-> !rsp_data_ff.accepted)
      else $error("read result also reports a stored fix");

endmodule
